[rtl/tkst_pkg.sv]
// Package for the top-k similarity tracker: sizes, item layouts,
// controller states and the command/status groups. No dependencies.
package tkst_pkg;

  localparam int LIST_DEPTH = 10;
  localparam int MODEL_BITS = 12;
  localparam int VIEW_BITS  = 7;
  localparam int SCORE_W    = 32;
  localparam int RANK_W     = 4;
  localparam int VOTE_W     = 4;
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  typedef enum logic {
    OP_CAND   = 1'b0,
    OP_FINISH = 1'b1
  } opcode_t;

  typedef struct packed {
    logic                       opcode;
    logic [MODEL_BITS-1:0]      model_id;
    logic [VIEW_BITS-1:0]       view_id;
    logic signed [SCORE_W-1:0]  score;
  } in_item_t;

  typedef struct packed {
    logic [RANK_W-1:0]          rank;
    logic [MODEL_BITS-1:0]      out_model;
    logic [VIEW_BITS-1:0]       out_view;
    logic signed [SCORE_W-1:0]  out_score;
    logic [VOTE_W-1:0]          model_votes;
    logic                       empty_res;
    logic                       last;
  } out_item_t;

  typedef struct packed {
    logic [MODEL_BITS-1:0]      model;
    logic [VIEW_BITS-1:0]       view;
    logic signed [SCORE_W-1:0]  score;
  } entry_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

  typedef struct packed {
    logic insert;      // candidate accepted this cycle
    logic start_emit;  // finish accepted, rewind read index
    logic load_out;    // load next ranked entry into output register
    logic clear;       // drop the list after its last entry
  } cmd_t;

  typedef struct packed {
    logic slot_free;   // output register empty or being drained
    logic emit_last;   // current entry is the final one of the run
  } status_t;

endpackage

[rtl/tkst_ctrl.sv]
// Controller for the top-k similarity tracker: request acceptance and
// list readout sequencing. Depends on tkst_pkg.
module tkst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_ready,
  input  tkst_pkg::status_t sts,
  output tkst_pkg::cmd_t    cmd
);

  tkst_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tkst_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      tkst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == tkst_pkg::OP_FINISH) begin
            cmd.start_emit = 1'b1;
            state_nxt      = tkst_pkg::ST_EMIT;
          end else begin
            cmd.insert = 1'b1;
          end
        end
      end
      tkst_pkg::ST_EMIT: begin
        if (sts.slot_free) begin
          cmd.load_out = 1'b1;
          if (sts.emit_last) begin
            cmd.clear = 1'b1;
            state_nxt = tkst_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = tkst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/tkst_datapath.sv]
// Datapath for the top-k similarity tracker: sorted list registers with
// parallel compare-and-shift insertion, vote counting and output register.
// Depends on tkst_pkg.
module tkst_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  tkst_pkg::in_item_t  in_data,
  input  tkst_pkg::cmd_t      cmd,
  output tkst_pkg::status_t   sts,
  input  logic                out_ready,
  output logic                out_valid,
  output tkst_pkg::out_item_t out_data
);

  localparam int D = tkst_pkg::LIST_DEPTH;

  tkst_pkg::entry_t                list_r [D];
  tkst_pkg::entry_t                list_nxt [D];
  logic [tkst_pkg::CNT_W-1:0]      count_r;
  logic [tkst_pkg::IDX_W-1:0]      idx_r;
  logic                            out_valid_r;
  tkst_pkg::out_item_t             out_r, out_nxt;

  logic [D-1:0]                    keep;
  logic                            full;
  logic                            do_write;
  tkst_pkg::entry_t                new_ent;
  tkst_pkg::entry_t                cur_ent;
  logic [tkst_pkg::VOTE_W-1:0]     votes;

  assign full = (count_r == tkst_pkg::CNT_W'(D));

  assign new_ent.model = in_data.model_id;
  assign new_ent.view  = in_data.view_id;
  assign new_ent.score = in_data.score;

  // Entries at or above the newcomer stay put; the list is sorted, so keep
  // is a prefix and the newcomer lands right after it.
  always_comb begin
    for (int k = 0; k < D; k++) begin
      keep[k] = (tkst_pkg::CNT_W'(k) < count_r) && (list_r[k].score >= in_data.score);
    end
    list_nxt[0] = keep[0] ? list_r[0] : new_ent;
    for (int k = 1; k < D; k++) begin
      if (keep[k]) begin
        list_nxt[k] = list_r[k];
      end else if (keep[k-1]) begin
        list_nxt[k] = new_ent;
      end else begin
        list_nxt[k] = list_r[k-1];
      end
    end
  end

  // Full list and not strictly above the tail: dropped.
  assign do_write = cmd.insert && !(full && keep[D-1]);

  always_ff @(posedge clk) begin
    if (do_write) begin
      for (int k = 0; k < D; k++) begin
        list_r[k] <= list_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.clear) begin
      count_r <= '0;
    end else if (do_write && !full) begin
      count_r <= count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else if (cmd.start_emit) begin
      idx_r <= '0;
    end else if (cmd.load_out && !sts.emit_last) begin
      idx_r <= idx_r + 1'b1;
    end
  end

  assign cur_ent = list_r[idx_r];

  always_comb begin
    votes = '0;
    for (int j = 0; j < D; j++) begin
      if ((tkst_pkg::CNT_W'(j) < count_r) && (list_r[j].model == cur_ent.model)) begin
        votes = votes + 1'b1;
      end
    end
  end

  assign sts.slot_free = !out_valid_r || out_ready;
  assign sts.emit_last = (count_r == '0) ||
                         (tkst_pkg::CNT_W'(idx_r) == count_r - 1'b1);

  always_comb begin
    out_nxt = '0;
    if (count_r == '0) begin
      out_nxt.empty_res = 1'b1;
      out_nxt.last      = 1'b1;
    end else begin
      out_nxt.rank        = tkst_pkg::RANK_W'(idx_r);
      out_nxt.out_model   = cur_ent.model;
      out_nxt.out_view    = cur_ent.view;
      out_nxt.out_score   = cur_ent.score;
      out_nxt.model_votes = votes;
      out_nxt.last        = sts.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[rtl/top_k_similarity_tracker.sv]
// Top-k similarity tracker. A candidate request is inserted by a parallel
// compare-and-shift, and one can be accepted every cycle while no readout runs.
// A finish request emits max(N,1) results, one per cycle from the output
// register while the receiver is ready; the first is loaded once the emit state
// is entered and the output register is free. No request is taken during readout.
// Reset (rst_n low, synchronous) empties the list and the output register.
module top_k_similarity_tracker (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tkst_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tkst_pkg::out_item_t out_data
);

  tkst_pkg::cmd_t    cmd;
  tkst_pkg::status_t sts;

  tkst_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_data.opcode),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tkst_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
